FILE: design/bpd_pkg.sv
// Shared types for the bounded positional deque.
// Holds the command codes and the cell control word that the top level hands to every cell.
// No dependencies.
`default_nettype none

package bpd_pkg;

  // Cell index width: covers every slot of the largest supported row (256).
  localparam int unsigned IDX_W = 8;

  // Command codes on cmd_i
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_ERASE  = 2'd3
  } cmd_e;

  // What the row of cells does this cycle
  typedef enum logic [1:0] {
    MODE_IDLE,    // every cell holds
    MODE_INSERT,  // below idx hold, idx loads, above idx take left neighbor
    MODE_ROTATE,  // below idx take right neighbor, idx loads, above idx hold
    MODE_DELETE   // idx and above take right neighbor
  } mode_e;

  typedef struct packed {
    mode_e            mode;
    logic [IDX_W-1:0] idx;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: design/bounded_positional_deque.sv
// Bounded positional deque: one command a cycle; done_o is a registered strobe
// in the cycle after start; the result is shown for exactly one cycle.
// Throughput is one command per cycle: the whole row of cells shifts, loads
// or holds in the same cycle, so busy is never raised.
// Reset clears the item count, the limit register and the strobe; slot
// contents are not cleared and no clearing pass runs.
// Top level; depends on bpd_pkg and bpd_cell.
`default_nettype none

module bounded_positional_deque import bpd_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [4:0]            cfg_wdata_i,
  // command
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic [1:0]            cmd_i,
  input  wire logic signed [8:0]     position_i,
  input  wire logic [DATA_WIDTH-1:0] item_value_i,
  // result
  output      logic                  done_o,
  output      logic [DATA_WIDTH-1:0] read_value_o,
  output      logic                  found_o,
  output      logic                  evicted_o,
  output      logic [CW-1:0]         items_held_o
);

  localparam int unsigned CMP_W = (CW > 8) ? CW : 8;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [4:0]            max_q;
  logic [CW-1:0]         count_q, count_d;
  logic                  done_q;
  logic [DATA_WIDTH-1:0] read_q, read_d;
  logic                  found_q, found_d, evict_q, evict_d;

  logic [DATA_WIDTH-1:0] slot_w [DEPTH];
  cell_ctl_t             ctl;
  logic                  accept;
  logic [CMP_W-1:0]      n_ext, pos_ext, lim_ext, last_ext, rd_ext;
  logic                  pos_neg, to_rear, full, nonempty;

  assign accept   = start && !busy;
  assign busy     = 1'b0;

  // Position decode
  assign pos_neg  = position_i[8];
  assign pos_ext  = CMP_W'(position_i[7:0]);
  assign n_ext    = CMP_W'(count_q);
  assign last_ext = n_ext - CMP_W'(1);
  assign to_rear  = pos_neg || (pos_ext >= n_ext);
  assign nonempty = count_q != '0;

  // Effective limit: zero or above the row size means the whole row
  assign lim_ext = (max_q == 5'd0 || CMP_W'(max_q) > CMP_W'(DEPTH)) ?
                   CMP_W'(DEPTH) : CMP_W'(max_q);
  assign full    = (n_ext == lim_ext) || (n_ext >= CMP_W'(DEPTH));

  // Slot addressed by get and remove (1-based; 0 and 1 mean the front)
  always_comb begin
    if (to_rear) begin
      rd_ext = last_ext;
    end else if (pos_ext < CMP_W'(2)) begin
      rd_ext = '0;
    end else begin
      rd_ext = pos_ext - CMP_W'(1);
    end
  end

  // Command decode: cell row control, next count and result
  always_comb begin
    ctl.mode = MODE_IDLE;
    ctl.idx  = '0;
    count_d  = count_q;
    read_d   = '0;
    found_d  = 1'b0;
    evict_d  = 1'b0;
    case (cmd_e'(cmd_i))
      CMD_ADD: begin
        evict_d = full;
        if (full && to_rear) begin
          // drop the front, shift all down, new word at the rear
          ctl.mode = MODE_ROTATE;
          ctl.idx  = IDX_W'(last_ext);
        end else begin
          // a full add at an inner spot overwrites the dropped rear
          ctl.mode = MODE_INSERT;
          ctl.idx  = to_rear ? IDX_W'(n_ext) : IDX_W'(pos_ext);
          if (!full) begin
            count_d = count_q + CW'(1);
          end
        end
      end
      CMD_GET, CMD_REMOVE: begin
        if (nonempty) begin
          found_d = 1'b1;
          read_d  = slot_w[AW'(rd_ext)];
          if (cmd_e'(cmd_i) == CMD_REMOVE) begin
            ctl.mode = MODE_DELETE;
            ctl.idx  = IDX_W'(rd_ext);
            count_d  = count_q - CW'(1);
          end
        end
      end
      CMD_ERASE: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    if (!accept) begin
      ctl.mode = MODE_IDLE;
    end
  end

  // Row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = slot_w[g];
    end else begin : g_mid_l
      assign left_w = slot_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = slot_w[g];
    end else begin : g_mid_r
      assign right_w = slot_w[g+1];
    end
    bpd_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .left_i (left_w),
      .right_i(right_w),
      .new_i  (item_value_i),
      .word_o (slot_w[g])
    );
  end

  // Control state: count, limit, strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      max_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  // Result word register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_q  <= read_d;
      found_q <= found_d;
      evict_q <= evict_d;
    end
  end

  assign done_o       = done_q;
  assign read_value_o = read_q;
  assign found_o      = found_q;
  assign evicted_o    = evict_q;
  assign items_held_o = count_q;

endmodule

`default_nettype wire

FILE: design/bpd_cell.sv
// One slot of the deque row: holds one word and moves it with its neighbors.
// Depends on bpd_pkg for the control word.
`default_nettype none

module bpd_cell import bpd_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CELL_IDX   = 0
) (
  input  wire logic                  clk_i,
  input  wire cell_ctl_t             ctl_i,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  input  wire logic [DATA_WIDTH-1:0] new_i,
  output      logic [DATA_WIDTH-1:0] word_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic                  below, at;

  // Position of this cell relative to the target slot
  assign below = MyIdx < ctl_i.idx;
  assign at    = MyIdx == ctl_i.idx;

  always_comb begin
    word_d = word_q;
    case (ctl_i.mode)
      MODE_INSERT: begin
        if (at) begin
          word_d = new_i;
        end else if (!below) begin
          word_d = left_i;
        end
      end
      MODE_ROTATE: begin
        if (at) begin
          word_d = new_i;
        end else if (below) begin
          word_d = right_i;
        end
      end
      MODE_DELETE: begin
        if (!below) begin
          word_d = right_i;
        end
      end
      default: begin
        word_d = word_q;
      end
    endcase
  end

  // Slot contents are payload: no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

FILE: design/bpd_checker.sv
// Port-level checks for the bounded positional deque, bound to the top level.
// Depends on bounded_positional_deque ports only.
`default_nettype none

module bpd_checker #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  done_o,
  input wire logic [DATA_WIDTH-1:0] read_value_o,
  input wire logic                  found_o,
  input wire logic                  evicted_o,
  input wire logic [CW-1:0]         items_held_o
);

  // Every accepted command gives a result word in the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rst_ni && start && !busy) |=> done_o)
    else $error("accepted command gave no result");

  // No result word without a command
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(rst_ni && start && !busy))
    else $error("result word without a command");

  // A read and an eviction never come from the same command
  a_found_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(found_o && evicted_o))
    else $error("found and evicted both set");

  // Empty read returns zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (read_value_o == '0))
    else $error("nonzero data without a hit");

  // Count never exceeds the row size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (items_held_o <= CW'(DEPTH)))
    else $error("item count above capacity");

endmodule

bind bounded_positional_deque bpd_checker #(
  .DEPTH     (DEPTH),
  .DATA_WIDTH(DATA_WIDTH)
) u_bpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .read_value_o(read_value_o),
  .found_o     (found_o),
  .evicted_o   (evicted_o),
  .items_held_o(items_held_o)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// Testbench for bounded_positional_deque: directed table, then random command phases.
// Untyped results are checked against a local mirror of the deque contents and item limit.
// Depends on the RTL only (bounded_positional_deque, bpd_pkg, bpd_cell).
`default_nettype none

module testbench import bpd_pkg::*;;

  localparam int DEPTH      = 16;
  localparam int WATCHDOG   = 500;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_LEN  = 104;

  typedef struct packed {
    logic [31:0] value;
    logic        found;
    logic        evicted;
    logic [4:0]  held;
  } outcome_t;

  // one row of the directed table; cfg rows carry the limit in val
  typedef struct packed {
    bit               is_cfg;
    cmd_e             op;
    logic signed [8:0] pos;
    logic [31:0]      val;
    bit               typed;
    outcome_t         want;
  } row_t;

  localparam logic signed [8:0] REAR = -9'sd1;
  localparam logic signed [8:0] FAR  = 9'sd255;
  localparam outcome_t NONE = '0;

  localparam row_t PLAN [26] = '{
    // empty deque right after reset
    '{1'b0, CMD_GET,    9'sd0, 32'h0,        1'b1, NONE},
    '{1'b0, CMD_REMOVE, REAR,  32'h0,        1'b1, NONE},
    '{1'b0, CMD_ERASE,  9'sd0, 32'h0,        1'b1, NONE},
    '{1'b0, CMD_ADD,    9'sd0, 32'hFFFFFFFF, 1'b1, '{32'h0, 1'b0, 1'b0, 5'd1}},
    '{1'b0, CMD_ADD,    REAR,  32'h00000000, 1'b1, '{32'h0, 1'b0, 1'b0, 5'd2}},
    // middle insert and rear by overshoot
    '{1'b0, CMD_ADD,    9'sd1, 32'hA5A5A5A5, 1'b0, NONE},
    '{1'b0, CMD_ADD,    FAR,   32'h5A5A5A5A, 1'b0, NONE},
    // lookups: 0 and 1 both front, -1 and overshoot rear
    '{1'b0, CMD_GET,    9'sd0, 32'h0,        1'b0, NONE},
    '{1'b0, CMD_GET,    9'sd1, 32'h0,        1'b0, NONE},
    '{1'b0, CMD_GET,    9'sd2, 32'h0,        1'b0, NONE},
    '{1'b0, CMD_GET,    9'sd3, 32'h0,        1'b0, NONE},
    '{1'b0, CMD_GET,    REAR,  32'h0,        1'b0, NONE},
    '{1'b0, CMD_GET,    FAR,   32'h0,        1'b0, NONE},
    '{1'b0, CMD_REMOVE, 9'sd2, 32'h0,        1'b0, NONE},
    '{1'b0, CMD_REMOVE, FAR,   32'h0,        1'b0, NONE},
    // limit 2 with two held: rear add drops front, others drop rear
    '{1'b1, CMD_ADD,    9'sd0, 32'd2,        1'b0, NONE},
    '{1'b0, CMD_ADD,    REAR,  32'h01234567, 1'b0, NONE},
    '{1'b0, CMD_ADD,    9'sd0, 32'h89ABCDEF, 1'b0, NONE},
    '{1'b0, CMD_ADD,    9'sd1, 32'hDEADBEEF, 1'b0, NONE},
    // limit lowered below the count: add goes in without eviction
    '{1'b1, CMD_ADD,    9'sd0, 32'd1,        1'b0, NONE},
    '{1'b0, CMD_ADD,    REAR,  32'hCAFEF00D, 1'b0, NONE},
    '{1'b0, CMD_GET,    9'sd2, 32'h0,        1'b0, NONE},
    '{1'b0, CMD_REMOVE, 9'sd0, 32'h0,        1'b0, NONE},
    '{1'b1, CMD_ADD,    9'sd0, 32'd16,       1'b0, NONE},
    '{1'b0, CMD_ERASE,  9'sd0, 32'h0,        1'b1, NONE},
    '{1'b0, CMD_GET,    9'sd1, 32'h0,        1'b1, NONE}
  };

  localparam logic [4:0] PHASE_LIMIT [NUM_PHASES] = '{
    5'd0, 5'd16, 5'd1, 5'd2, 5'd16, 5'd7, 5'd0, 5'd15, 5'd1, 5'd16, 5'd12, 5'd0
  };

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic [4:0]        cfg_wdata_i  = '0;
  logic              start        = 1'b0;
  logic              busy;
  logic [1:0]        cmd_i        = '0;
  logic signed [8:0] position_i   = '0;
  logic [31:0]       item_value_i = '0;
  logic              done_o;
  logic [31:0]       read_value_o;
  logic              found_o;
  logic              evicted_o;
  logic [4:0]        items_held_o;

  bounded_positional_deque dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .found_o      (found_o),
    .evicted_o    (evicted_o),
    .items_held_o (items_held_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mirror of the deque
  logic [31:0] mirror_slots [DEPTH];
  int          mirror_count = 0;
  int          mirror_limit = 0;

  outcome_t pending_outcomes [$];

  int n_errors  = 0;
  int n_words   = 0;
  int n_results = 0;
  int n_evicted = 0;
  int n_found   = 0;
  int n_cfg     = 0;
  int quiet_cycles = 0;

  // close the gap left by the word at idx
  function automatic void drop_slot(int idx);
    int i;
    for (i = idx; i + 1 < mirror_count; i++) mirror_slots[i] = mirror_slots[i + 1];
    mirror_count--;
  endfunction

  // apply one command to the mirror, return the result word it should produce
  function automatic outcome_t predict_outcome(cmd_e op, logic signed [8:0] pos,
                                               logic [31:0] val);
    outcome_t r;
    int p;
    int idx;
    int lim;
    int i;
    r   = '0;
    p   = int'(pos);
    lim = (mirror_limit == 0 || mirror_limit > DEPTH) ? DEPTH : mirror_limit;
    case (op)
      CMD_ADD: begin
        // eviction side is decided on the count before the drop
        if (mirror_count == lim || mirror_count >= DEPTH) begin
          if (p < 0 || p >= mirror_count) drop_slot(0);
          else drop_slot(mirror_count - 1);
          r.evicted = 1'b1;
        end
        if (mirror_count == 0 || p == 0) idx = 0;
        else if (p < 0 || p >= mirror_count) idx = mirror_count;
        else idx = p;
        for (i = mirror_count; i > idx; i--) mirror_slots[i] = mirror_slots[i - 1];
        mirror_slots[idx] = val;
        mirror_count++;
      end
      CMD_GET, CMD_REMOVE: begin
        if (mirror_count != 0) begin
          if (p < 0 || p >= mirror_count) idx = mirror_count - 1;
          else if (p < 2) idx = 0;
          else idx = p - 1;
          r.value = mirror_slots[idx];
          r.found = 1'b1;
          if (op == CMD_REMOVE) drop_slot(idx);
        end
      end
      default: mirror_count = 0;
    endcase
    r.held = 5'(mirror_count);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at result %0d: got %h, want %h", field, n_results, got, want);
    n_errors++;
  endtask

  // present one word and hold it until accepted
  task automatic issue_word(cmd_e op, logic signed [8:0] pos, logic [31:0] val,
                            bit typed, outcome_t want);
    outcome_t pred;
    start        <= 1'b1;
    cmd_i        <= op;
    position_i   <= pos;
    item_value_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pred = predict_outcome(op, pos, val);
    pending_outcomes.push_back(typed ? want : pred);
    n_words++;
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // stop sending until every expected word is back
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_outcomes.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic write_limit(logic [4:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    mirror_limit  = int'(v);
    n_cfg++;
  endtask

  // result checker and watchdog
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni) begin
      if (done_o) begin
        n_results++;
        if (pending_outcomes.size() == 0) begin
          report_mismatch("unexpected word", read_value_o, 32'h0);
        end else begin
          want = pending_outcomes.pop_front();
          if (read_value_o !== want.value) report_mismatch("read_value", read_value_o, want.value);
          if (found_o !== want.found) report_mismatch("found", 32'(found_o), 32'(want.found));
          if (evicted_o !== want.evicted)
            report_mismatch("evicted", 32'(evicted_o), 32'(want.evicted));
          if (items_held_o !== want.held)
            report_mismatch("items_held", 32'(items_held_o), 32'(want.held));
          if (want.evicted) n_evicted++;
          if (want.found) n_found++;
        end
      end
      if ((start && !busy) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG);
        $display("[bounded_positional_deque] ERROR");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int               k;
    int               ph;
    int               idle_pct;
    int               roll;
    cmd_e             op;
    logic signed [8:0] pos;
    logic [31:0]      val;
    logic [4:0]       lim;

    for (k = 0; k < DEPTH; k++) mirror_slots[k] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (k = 0; k < $size(PLAN); k++) begin
      if (PLAN[k].is_cfg) begin
        settle();
        write_limit(PLAN[k].val[4:0]);
      end else begin
        issue_word(PLAN[k].op, PLAN[k].pos, PLAN[k].val, PLAN[k].typed, PLAN[k].want);
      end
    end

    // random phases: sender gaps 15%, then 57%, then none
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct = (ph < 4) ? 15 : (ph < 8) ? 57 : 0;
      lim      = (ph == 4) ? 5'($urandom_range(0, 16)) : PHASE_LIMIT[ph];
      settle();
      write_limit(lim);
      for (k = 0; k < PHASE_LEN; k++) begin
        // half are adds so the deque fills and evicts; erase is rare
        roll = $urandom_range(0, 99);
        if (roll < 50) op = CMD_ADD;
        else if (roll < 74) op = CMD_GET;
        else if (roll < 98) op = CMD_REMOVE;
        else op = CMD_ERASE;
        roll = $urandom_range(0, 99);
        if (roll < 10) pos = 9'sd0;
        else if (roll < 20) pos = 9'sd1;
        else if (roll < 35) pos = REAR;
        else if (roll < 45) pos = FAR;
        else if (roll < 55) pos = 9'($urandom_range(2, 255));
        else pos = 9'($urandom_range(0, 17));
        roll = $urandom_range(0, 99);
        if (roll < 5) val = 32'h0;
        else if (roll < 10) val = 32'hFFFFFFFF;
        else val = $urandom;
        if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 4));
        else if ($urandom_range(0, 99) == 0) settle();
        issue_word(op, pos, val, 1'b0, NONE);
      end
    end

    settle();
    repeat (6) @(posedge clk_i);
    $display("run: %0d commands (%0d from the table), %0d results, %0d limit writes",
             n_words, $size(PLAN) - 3, n_results, n_cfg);
    $display("run: %0d evictions, %0d hits on get/remove, limits 0 to 16", n_evicted, n_found);
    if (n_errors == 0) begin
      $display("[bounded_positional_deque] OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("[bounded_positional_deque] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
